/* hdl/roulette_wheel_selector_defines.svh */
// ----------------------------------------------------------------------------
// roulette_wheel_selector_defines
// Assertion macros shared by the roulette wheel selector RTL.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTOR_DEFINES_SVH
`define ROULETTE_WHEEL_SELECTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rws_pkg.sv */
// ----------------------------------------------------------------------------
// rws_pkg
// Types, constants and codes for the roulette wheel selector.
// ----------------------------------------------------------------------------
package rws_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int MODE_W   = 2;
    localparam int WEIGHT_W = 16;
    localparam int RAND_W   = 16;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 22;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Request modes
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [WEIGHT_W-1:0] weight;
        logic [RAND_W-1:0]   random_value;
    } req_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  selected_index;
        logic [STATUS_W-1:0] status;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_DONE
    } state_t;

endpackage

/* hdl/rws_ram.sv */
// ----------------------------------------------------------------------------
// rws_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/roulette_wheel_selector.sv */
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Clear and append need no search; the result is registered on the next edge.
// A draw is a binary search through the cumulative table: each step does one RAM read
// and compare, and the selected index goes out from the done state.
// One request is in work at a time; the next is taken once the result is out.
// Reset (rst_n, async) empties the table; stored entries are not cleared.
// ----------------------------------------------------------------------------
`include "roulette_wheel_selector_defines.svh"

module roulette_wheel_selector
    import rws_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [ADDR_W-1:0]   lo_reg, lo_next;
    logic [ADDR_W-1:0]   hi_reg, hi_next;
    logic [ADDR_W-1:0]   mid_reg, mid_next;
    logic [RAND_W-1:0]   rnd_reg, rnd_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_item_t           rsp_reg, rsp_next;

    logic                req_accept;
    logic                rsp_free;
    logic                table_full;
    logic [TOTAL_W:0]    sum_wide;
    logic [TOTAL_W-1:0]  sum_sat;
    logic [COUNT_W-1:0]  last_idx;

    logic                wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [TOTAL_W-1:0]  rd_data;

    logic                greater;
    logic [ADDR_W-1:0]   lo_step;
    logic [ADDR_W-1:0]   hi_step;
    logic [ADDR_W-1:0]   mid_step;

    // Handshake
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = (state_reg != ST_IDLE) || !rsp_free;
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Append arithmetic with saturation
    assign table_full = (count_reg == COUNT_W'(MAX_ENTRIES));
    assign sum_wide   = {1'b0, total_reg} + (TOTAL_W + 1)'(req.weight);
    assign sum_sat    = sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
    assign last_idx   = count_reg - COUNT_W'(1);

    // One search step: narrow [lo, hi] around the probed entry
    assign greater  = rd_data > TOTAL_W'(rnd_reg);
    assign lo_step  = greater ? lo_reg : mid_reg + ADDR_W'(1);
    assign hi_step  = greater ? mid_reg : hi_reg;
    assign mid_step = lo_step + ((hi_step - lo_step) >> 1);

    assign wr_en = req_accept && (req.mode == MODE_APPEND) && !table_full;

    rws_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(count_reg)),
        .wr_data (sum_sat),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req.mode == MODE_DRAW))
                begin
                    if (count_reg > COUNT_W'(1))
                    begin
                        state_next = ST_COMPARE;
                    end
                    else if (count_reg == COUNT_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_COMPARE:
            begin
                if (lo_step >= hi_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result outputs
    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        rnd_next       = rnd_reg;
        rd_en          = 1'b0;
        rd_addr        = mid_step;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    rsp_next.selected_index = '0;
                    rsp_next.status         = STATUS_OK;
                    rsp_valid_next          = 1'b1;
                    case (req.mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            if (table_full)
                            begin
                                rsp_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                total_next = sum_sat;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        MODE_DRAW:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                // Hold the result until the search ends
                                rsp_valid_next = 1'b0;
                                rnd_next       = req.random_value;
                                lo_next        = '0;
                                hi_next        = ADDR_W'(last_idx);
                                mid_next       = ADDR_W'(last_idx >> 1);
                                rd_en          = 1'b1;
                                rd_addr        = ADDR_W'(last_idx >> 1);
                            end
                        end
                        default:
                        begin
                            // Unused mode: table unchanged, an OK result with index 0 still goes out
                        end
                    endcase
                end
            end
            ST_COMPARE:
            begin
                // Advance one step and probe the next midpoint
                lo_next  = lo_step;
                hi_next  = hi_step;
                mid_next = mid_step;
                rd_en    = (lo_step < hi_step);
                rd_addr  = mid_step;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.selected_index = INDEX_W'(lo_reg);
                    rsp_next.status         = STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        rnd_reg <= rnd_next;
        rsp_reg <= rsp_next;
    end

    // Checks
    `RWS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_W'(MAX_ENTRIES), "entry count overflow")
    `RWS_ASSERT_NOW(a_probe_in_range, state_reg == ST_COMPARE, (lo_reg <= mid_reg) && (mid_reg < hi_reg), "probe outside search window")
    `RWS_ASSERT_NOW(a_hi_below_count, state_reg == ST_COMPARE, COUNT_W'(hi_reg) < count_reg, "search window beyond table")
    `RWS_ASSERT_NOW(a_done_index_valid, state_reg == ST_DONE, COUNT_W'(lo_reg) < count_reg, "selected index beyond table")
    `RWS_ASSERT_NEXT(a_done_delivers, (state_reg == ST_DONE) && rsp_free, rsp_valid_reg && (state_reg == ST_IDLE), "draw result not delivered")

endmodule

/* test/roulette_wheel_selector_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector_test
// Self-checking bench for the roulette wheel selector. Clear, append and
// draw requests go in, in bursts with random gaps, while the result side
// stalls in random phases. A scoreboard keeps its own cumulative table and
// checks every result; each draw against a plain linear search of that table.
// ----------------------------------------------------------------------------
module roulette_wheel_selector_test
    import rws_pkg::*;
();

    // Mode three has no meaning to the block; it must leave the table unchanged
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 1800;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow wheel plus the queue of selections still owed
    // ------------------------------------------------------------------------
    class selection_scoreboard;
        logic [TOTAL_W-1:0] cumulative [MAX_ENTRIES];
        logic [TOTAL_W-1:0] running_total = '0;
        int unsigned        entry_count   = 0;
        rsp_item_t          pending_selections [$];
        int unsigned        errors        = 0;

        // Find the first slot whose cumulative sum lies above the point, else the last slot
        function int unsigned first_slot_above(logic [RAND_W-1:0] point);
            int unsigned slot;
            slot = 0;
            while (slot + 1 < entry_count && cumulative[slot] <= {6'd0, point})
                slot++;
            return slot;
        endfunction

        // Apply one accepted request to the wheel and queue its result
        function void note_request(req_item_t item);
            rsp_item_t        expected;
            logic [TOTAL_W:0] sum;
            int unsigned      slot;
            expected.selected_index = '0;
            expected.status         = STATUS_OK;
            case (item.mode)
                MODE_CLEAR:
                begin
                    entry_count   = 0;
                    running_total = '0;
                end
                MODE_APPEND:
                begin
                    if (entry_count >= MAX_ENTRIES)
                    begin
                        expected.status = STATUS_FULL;
                    end
                    else
                    begin
                        sum = {1'b0, running_total} + {7'd0, item.weight};
                        if (sum > {1'b0, TOTAL_MAX})
                            sum = {1'b0, TOTAL_MAX};
                        running_total            = sum[TOTAL_W-1:0];
                        cumulative[entry_count]  = running_total;
                        entry_count++;
                    end
                end
                MODE_DRAW:
                begin
                    if (entry_count == 0)
                    begin
                        expected.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        slot = first_slot_above(item.random_value);
                        expected.selected_index = slot[INDEX_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
            pending_selections.push_back(expected);
        endfunction

        // Compare one accepted result with the oldest owed selection
        function void check_selection(rsp_item_t got);
            rsp_item_t want;
            if (pending_selections.size() == 0)
            begin
                $error("result with nothing pending: selected_index %0d status %0d",
                       got.selected_index, got.status);
                errors++;
                return;
            end
            want = pending_selections.pop_front();
            if (got.selected_index !== want.selected_index)
            begin
                $error("selected_index: expected %0d, actual %0d",
                       want.selected_index, got.selected_index);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    selection_scoreboard sb;
    int unsigned         idle_cycles   = 0;
    int unsigned         burst_left    = 0;
    int unsigned         requests_sent = 0;

    roulette_wheel_selector dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [15:0] rand_word();
        return 16'($urandom());
    endfunction

    function automatic req_item_t make_item(logic [MODE_W-1:0] mode,
                                            logic [WEIGHT_W-1:0] weight,
                                            logic [RAND_W-1:0] point);
        req_item_t item;
        item.mode         = mode;
        item.weight       = weight;
        item.random_value = point;
        return item;
    endfunction

    // Pick a draw point: exact cumulative boundaries, points inside the
    // total, points past it, and the two extremes
    function automatic logic [RAND_W-1:0] pick_draw_point();
        logic [TOTAL_W-1:0] boundary;
        int unsigned        ceiling;
        case ($urandom_range(0, 4))
            0:
            begin
                if (sb.entry_count != 0)
                begin
                    boundary = sb.cumulative[$urandom_range(0, sb.entry_count - 1)];
                    if (boundary <= 22'h00FFFF)
                        return boundary[RAND_W-1:0] - RAND_W'($urandom_range(0, 1));
                end
                return rand_word();
            end
            1, 2:
            begin
                ceiling = (sb.running_total > 22'h00FFFF) ? 32'hFFFF
                                                          : 32'(sb.running_total);
                return RAND_W'($urandom_range(0, ceiling));
            end
            3:
                return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default:
                return rand_word();
        endcase
    endfunction

    // Drive one request and hold it until the block takes it
    task automatic send_request(input req_item_t item);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 12);
            if (gap != 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                req       <= make_item(2'($urandom()), rand_word(), rand_word());
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(item);
        if (item.mode != MODE_UNUSED)
            requests_sent++;
    endtask

    // Stall the result side in phases of random density
    initial
    begin
        int unsigned phase_left;
        int unsigned stall_pct;
        rsp_stall  = 1'b0;
        phase_left = 0;
        stall_pct  = 0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(5, 60);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Check results and watch for a hung handshake
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_selection(rsp);
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned        appends;
        int unsigned        draws;
        int unsigned        k;
        logic [WEIGHT_W-1:0] weight_cap;
        logic [WEIGHT_W-1:0] weight;

        sb        = new();
        req_valid = 1'b0;
        req       = '0;
        rst_n     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty draws, ignored mode, field extremes, boundaries
        send_request(make_item(MODE_DRAW, 16'h0000, 16'hFFFF));
        send_request(make_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF));
        send_request(make_item(MODE_DRAW, 16'hFFFF, 16'h0000));
        send_request(make_item(MODE_APPEND, 16'h0000, 16'hFFFF));
        send_request(make_item(MODE_APPEND, 16'hFFFF, 16'h0000));
        send_request(make_item(MODE_APPEND, 16'h0001, 16'h0000));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'h0000));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'hFFFE));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'hFFFF));
        send_request(make_item(MODE_APPEND, 16'hFFFF, 16'h0000));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'h8000));
        send_request(make_item(MODE_UNUSED, 16'h5A5A, 16'hA5A5));
        send_request(make_item(MODE_DRAW, 16'hFFFF, 16'hFFFF));
        send_request(make_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'h1234));
        send_request(make_item(MODE_APPEND, 16'h0001, 16'h0000));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'h0000));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'h0001));
        send_request(make_item(MODE_APPEND, 16'h8000, 16'h0000));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'h8000));
        send_request(make_item(MODE_DRAW, 16'h0000, 16'hFFFF));
        send_request(make_item(MODE_CLEAR, 16'h0000, 16'h0000));

        // Random: mostly well-formed wheels, some noise
        while (requests_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // Build a fresh wheel, sometimes past full, then spin it
                send_request(make_item(MODE_CLEAR, rand_word(), rand_word()));
                appends = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 72)
                                                      : $urandom_range(0, 16);
                case ($urandom_range(0, 2))
                    0:       weight_cap = 16'h00FF;
                    1:       weight_cap = 16'h0FFF;
                    default: weight_cap = 16'hFFFF;
                endcase
                for (k = 0; k < appends; k++)
                begin
                    weight = ($urandom_range(0, 9) == 0) ? 16'h0000
                             : WEIGHT_W'($urandom_range(0, 32'(weight_cap)));
                    send_request(make_item(MODE_APPEND, weight, rand_word()));
                    if ($urandom_range(0, 7) == 0)
                        send_request(make_item(MODE_DRAW, rand_word(), pick_draw_point()));
                end
                draws = $urandom_range(1, 20);
                for (k = 0; k < draws; k++)
                    send_request(make_item(MODE_DRAW, rand_word(), pick_draw_point()));
            end
            else
            begin
                // Throw in arbitrary requests of any mode
                draws = $urandom_range(1, 8);
                for (k = 0; k < draws; k++)
                    send_request(make_item(2'($urandom()), rand_word(), rand_word()));
            end
        end

        // Drop valid, drain the owed results, then let the block settle
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending_selections.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_selections.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rws_pkg.sv
hdl/rws_ram.sv
hdl/roulette_wheel_selector.sv
test/roulette_wheel_selector_test.sv
